// ===== src/mtsdc_pkg.sv =====
package mtsdc_pkg;

    localparam int MAX_TRACK_WORDS = 8192;
    localparam int LEN_W           = 14;
    localparam int IDX_W           = 13;

    localparam logic [31:0]      SYNC_RESET  = 32'h8944_8944;
    localparam logic [31:0]      KEY_RESET   = 32'h2256_8229;
    localparam logic [LEN_W-1:0] WORDS_RESET = 14'd3136;
    localparam logic [LEN_W-1:0] MIN_WORDS   = 14'd4;
    localparam logic [LEN_W-1:0] MAX_WORDS   = LEN_W'(MAX_TRACK_WORDS);
    localparam logic [15:0]      MFM_MASK    = 16'h5555;

    // Configuration register indexes.
    localparam logic [1:0] REG_SYNC_PATTERN = 2'd0;
    localparam logic [1:0] REG_CHECKSUM_KEY = 2'd1;
    localparam logic [1:0] REG_TRACK_WORDS  = 2'd2;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_DATA = 2'd1,
        PH_IDLE = 2'd2
    } phase_t;

    typedef struct packed {
        logic raw_bit;
        logic restart;
    } in_item_t;

    typedef struct packed {
        logic [15:0]      data_word;
        logic [IDX_W-1:0] word_index;
        logic             last;
        logic             checksum_ok;
    } out_item_t;

    typedef struct packed {
        logic [31:0]      sync_pattern;
        logic [31:0]      checksum_key;
        logic [LEN_W-1:0] track_words;
    } cfg_t;

endpackage

// ===== src/mtsdc_core.sv =====
module mtsdc_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  mtsdc_pkg::in_item_t item,
    input  mtsdc_pkg::cfg_t     cfg,
    output logic                res_valid,
    output mtsdc_pkg::out_item_t res_item
);
    import mtsdc_pkg::*;

    logic [31:0]      raw_shift_reg, raw_shift_next;
    logic [4:0]       bit_count_reg, bit_count_next;
    logic [IDX_W-1:0] word_count_reg, word_count_next;
    phase_t           phase_reg, phase_next;
    logic [31:0]      running_sum_reg, running_sum_next;
    logic [15:0]      high_half_reg, high_half_next;

    logic [31:0]      shifted;
    logic             sync_hit;
    logic             word_done;
    logic [15:0]      word;
    logic [31:0]      pair;
    logic [LEN_W-1:0] len_clamped;
    logic [LEN_W-1:0] eff_len;
    logic             is_last;
    logic             ok;

    assign shifted   = {raw_shift_reg[30:0], item.raw_bit};
    assign sync_hit  = (shifted == cfg.sync_pattern);
    assign word_done = (bit_count_reg == 5'd31);
    assign word      = ((shifted[31:16] & MFM_MASK) << 1) | (shifted[15:0] & MFM_MASK);
    assign pair      = {high_half_reg, word};

    always_comb
    begin
        if (cfg.track_words < MIN_WORDS)
        begin
            len_clamped = MIN_WORDS;
        end
        else if (cfg.track_words > MAX_WORDS)
        begin
            len_clamped = MAX_WORDS;
        end
        else
        begin
            len_clamped = cfg.track_words;
        end
        eff_len = {len_clamped[LEN_W-1:1], 1'b0};
    end

    assign is_last = ({1'b0, word_count_reg} + LEN_W'(1)) >= eff_len;
    assign ok      = (pair == running_sum_reg);

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (step)
        begin
            if (item.restart)
            begin
                phase_next = PH_HUNT;
            end
            else
            begin
                unique case (phase_reg)
                    PH_HUNT:
                    begin
                        if (sync_hit)
                        begin
                            phase_next = PH_DATA;
                        end
                    end
                    PH_DATA:
                    begin
                        if (word_done && is_last)
                        begin
                            phase_next = ok ? PH_IDLE : PH_HUNT;
                        end
                    end
                    PH_IDLE:
                    begin
                        phase_next = PH_IDLE;
                    end
                    default:
                    begin
                        phase_next = PH_HUNT;
                    end
                endcase
            end
        end
    end

    // Datapath and result.
    always_comb
    begin
        raw_shift_next   = raw_shift_reg;
        bit_count_next   = bit_count_reg;
        word_count_next  = word_count_reg;
        running_sum_next = running_sum_reg;
        high_half_next   = high_half_reg;
        res_valid        = 1'b0;
        res_item         = '{data_word:   word,
                             word_index:  word_count_reg,
                             last:        is_last,
                             checksum_ok: is_last && ok};
        if (step)
        begin
            if (item.restart)
            begin
                raw_shift_next   = '0;
                bit_count_next   = '0;
                word_count_next  = '0;
                running_sum_next = '0;
                high_half_next   = '0;
            end
            else if (phase_reg == PH_HUNT)
            begin
                raw_shift_next = shifted;
                if (sync_hit)
                begin
                    bit_count_next   = '0;
                    word_count_next  = '0;
                    running_sum_next = '0;
                    high_half_next   = '0;
                end
            end
            else if (phase_reg == PH_DATA)
            begin
                raw_shift_next = shifted;
                if (!word_done)
                begin
                    bit_count_next = bit_count_reg + 5'd1;
                end
                else
                begin
                    res_valid      = 1'b1;
                    bit_count_next = '0;
                    if (is_last)
                    begin
                        word_count_next  = '0;
                        running_sum_next = '0;
                        high_half_next   = '0;
                    end
                    else
                    begin
                        word_count_next = word_count_reg + IDX_W'(1);
                        if (!word_count_reg[0])
                        begin
                            high_half_next = word;
                        end
                        else
                        begin
                            running_sum_next = running_sum_reg + (cfg.checksum_key ^ pair);
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_shift_reg   <= '0;
            bit_count_reg   <= '0;
            word_count_reg  <= '0;
            phase_reg       <= PH_HUNT;
            running_sum_reg <= '0;
            high_half_reg   <= '0;
        end
        else
        begin
            raw_shift_reg   <= raw_shift_next;
            bit_count_reg   <= bit_count_next;
            word_count_reg  <= word_count_next;
            phase_reg       <= phase_next;
            running_sum_reg <= running_sum_next;
            high_half_reg   <= high_half_next;
        end
    end

endmodule

// ===== src/mtsdc_out_stage.sv =====
module mtsdc_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  mtsdc_pkg::out_item_t load_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output mtsdc_pkg::out_item_t out_item
);
    import mtsdc_pkg::*;

    logic      valid_reg, valid_next;
    out_item_t item_reg;

    // A load only happens when the register is empty or being drained.
    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= load_item;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ===== src/mfm_track_sync_decode_check_unit.sv =====
// MFM track sync hunter, even/odd word decoder and checksum checker. One raw disk bit is
// taken per transfer, and a new bit can be taken in every cycle: the core updates its
// state once per step behind the input register, which sets that rate. A decoded word
// leaves through a one-entry output register, which is loaded on the step of the bit
// that completes it. The input side stalls only while that output register is full and
// not being taken. After a track whose checksum matched, raw bits are absorbed without
// effect until an item with restart set arrives; a bad track returns to sync hunting.
module mfm_track_sync_decode_check_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  mtsdc_pkg::in_item_t  in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output mtsdc_pkg::out_item_t out_item,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_addr,
    input  logic [31:0]          cfg_data
);
    import mtsdc_pkg::*;

    cfg_t      cfg_reg, cfg_next;
    logic      in_valid_reg, in_valid_next;
    in_item_t  in_item_reg;
    logic      advance;
    logic      res_valid;
    out_item_t res_item;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_SYNC_PATTERN: cfg_next.sync_pattern = cfg_data;
                REG_CHECKSUM_KEY: cfg_next.checksum_key = cfg_data;
                REG_TRACK_WORDS:  cfg_next.track_words  = cfg_data[LEN_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{sync_pattern: SYNC_RESET,
                         checksum_key: KEY_RESET,
                         track_words:  WORDS_RESET};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign advance  = in_valid_reg && (!out_valid || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_comb
    begin
        if (in_valid && in_ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_item_reg <= in_item;
        end
    end

    mtsdc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .item      (in_item_reg),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res_item  (res_item)
    );

    mtsdc_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .load_item (res_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

`ifndef NO_ASSERTIONS
    a_ok_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.checksum_ok |-> out_item.last)
        else $error("checksum_ok set on a word that is not the last");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled while the output register could take a word");

    a_result_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> advance && (!out_valid || out_ready))
        else $error("decoded word produced while the output register is blocked");
`endif

endmodule
